/* design/btpc_pkg.sv */
`timescale 1ns / 1ps
package btpc_pkg;
  localparam int DivW = 32;
  localparam logic [1:0] RegTemp  = 2'd0;
  localparam logic [1:0] RegPressA = 2'd1;
  localparam logic [1:0] RegPressB = 2'd2;
  localparam logic [1:0] RegPressC = 2'd3;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] temp;
    logic [31:0] p;
    logic        status;
  } result_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        big;
    logic [31:0] fine;
    logic [31:0] temp;
    logic        zero;
  } div_in_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    asr = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] w);
    sx16 = {{16{w[15]}}, w};
  endfunction
endpackage

/* design/btpc_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, plus the final
// pressure correction terms after the quotient.
module btpc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  btpc_pkg::div_in_t        din,
  input  logic [47:0]              cal_c,
  output logic                     out_valid,
  output btpc_pkg::result_t        dout
);
  localparam int N = btpc_pkg::DivW;

  logic [N:1]        vld;
  logic [31:0]       rem  [1:N];
  logic [31:0]       quo  [1:N];
  logic [31:0]       num  [1:N];
  btpc_pkg::div_in_t meta [1:N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic              vi;
    logic [31:0]       ri, qi, ni;
    btpc_pkg::div_in_t mi;
    logic [32:0]       tr;
    logic [32:0]       df;
    if (i == 0) begin : g_head
      assign vi = in_valid;
      assign ri = '0;
      assign qi = '0;
      assign ni = din.num;
      assign mi = din;
    end else begin : g_tail
      assign vi = vld[i];
      assign ri = rem[i];
      assign qi = quo[i];
      assign ni = num[i];
      assign mi = meta[i];
    end
    assign tr = {ri, ni[31]};
    assign df = tr - {1'b0, mi.den};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num[i+1]  <= {ni[30:0], 1'b0};
        meta[i+1] <= mi;
        if (!df[32]) begin
          rem[i+1] <= df[31:0];
          quo[i+1] <= {qi[30:0], 1'b1};
        end else begin
          rem[i+1] <= tr[31:0];
          quo[i+1] <= {qi[30:0], 1'b0};
        end
      end
    end
  end

  // post stage 1: p, x2 and p9 square term
  logic        v1, v2, v3;
  logic [31:0] p1r, sq1;
  btpc_pkg::div_in_t m1, m2;
  logic [31:0] p_q;
  assign p_q = meta[N].big ? {quo[N][30:0], 1'b0} : quo[N];
  logic [31:0] a2, b2, p2r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= vld[N];
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= meta[N];
      p1r <= p_q;
      sq1 <= 32'({3'b0, p_q[31:3]} * {3'b0, p_q[31:3]});
      m2  <= m1;
      p2r <= p1r;
      a2  <= btpc_pkg::asr(32'(btpc_pkg::sx16(cal_c[47:32]) * {13'b0, sq1[31:13]}), 12);
      b2  <= btpc_pkg::asr(32'({2'b0, p1r[31:2]} * btpc_pkg::sx16(cal_c[31:16])), 13);
      dout.fine <= m2.fine;
      dout.temp <= m2.temp;
      dout.status <= m2.zero;
      dout.p <= m2.zero ? '0 :
                p2r + btpc_pkg::asr(a2 + b2 + btpc_pkg::sx16(cal_c[15:0]), 4);
    end
  end
  assign out_valid = v3;
endmodule

/* design/baro_temp_press_compensation_core.sv */
`timescale 1ns / 1ps
// Pipeline from input transaction to result: 8 front stages, 32 divider
// stages, 3 correction stages, 1 output register.
// Throughput: one transaction per cycle; the whole pipe advances together and
// holds when the output register is full and not taken.
// Reset (rst, synchronous): calibration registers clear to 0, pipe empties.
module baro_temp_press_compensation_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [19:0]  raw_temperature,
  input  logic [19:0]  raw_pressure,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  temperature_centi,
  output logic [31:0]  fine_temperature,
  output logic [31:0]  pressure_pa,
  output logic         status,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  // calibration registers, 8-byte stride
  logic [47:0] cal [4];
  logic [1:0]  ridx;
  assign ridx   = paddr[4:3];
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) cal[i] <= '0;
    end else if (psel && penable && pwrite) begin
      cal[ridx] <= pwdata[47:0];
    end
  end
  always_comb begin
    prdata = {16'b0, cal[ridx]};
  end

  // Whole pipe moves when the output slot is free or being drained.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  assign t1 = {16'b0, cal[btpc_pkg::RegTemp][15:0]};
  assign t2 = btpc_pkg::sx16(cal[btpc_pkg::RegTemp][31:16]);
  assign t3 = btpc_pkg::sx16(cal[btpc_pkg::RegTemp][47:32]);
  assign p1 = {16'b0, cal[btpc_pkg::RegPressA][15:0]};
  assign p2 = btpc_pkg::sx16(cal[btpc_pkg::RegPressA][31:16]);
  assign p3 = btpc_pkg::sx16(cal[btpc_pkg::RegPressA][47:32]);
  assign p4 = btpc_pkg::sx16(cal[btpc_pkg::RegPressB][15:0]);
  assign p5 = btpc_pkg::sx16(cal[btpc_pkg::RegPressB][31:16]);
  assign p6 = btpc_pkg::sx16(cal[btpc_pkg::RegPressB][47:32]);

  // front pipe valid bits
  logic [7:0] v;
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:0], in_valid};
    end
  end

  // s1: temperature products
  logic [19:0] ap1, ap2, ap3, ap4, ap5, ap6, ap7;
  logic [31:0] ta1, dd1;
  always_ff @(posedge clk) begin
    if (en) begin
      ap1 <= raw_pressure;
      ta1 <= 32'(32'(({12'b0, raw_temperature} >> 3) - (t1 << 1)) * t2);
      dd1 <= 32'(({12'b0, raw_temperature} >> 4) - t1);
    end
  end
  // s2: square of d
  logic [31:0] ta2, sq2;
  always_ff @(posedge clk) begin
    if (en) begin
      ap2 <= ap1;
      ta2 <= btpc_pkg::asr(ta1, 11);
      sq2 <= 32'(dd1 * dd1);
    end
  end
  // s3: t3 term
  logic [31:0] ta3, tb3;
  always_ff @(posedge clk) begin
    if (en) begin
      ap3 <= ap2;
      ta3 <= ta2;
      tb3 <= 32'(btpc_pkg::asr(sq2, 12) * t3);
    end
  end
  // s4: fine, pressure var a, temperature
  logic [31:0] fine4, temp4, a4;
  logic [31:0] f_c;
  assign f_c = ta3 + btpc_pkg::asr(tb3, 14);
  always_ff @(posedge clk) begin
    if (en) begin
      ap4   <= ap3;
      fine4 <= f_c;
      temp4 <= btpc_pkg::asr(32'(f_c * 32'd5) + 32'd128, 8);
      a4    <= btpc_pkg::asr(f_c, 1) - 32'd64000;
    end
  end
  // s5: q, a*p5, p2*a
  logic [31:0] fine5, temp5, q5, ap5m, p2a5;
  always_ff @(posedge clk) begin
    if (en) begin
      ap5   <= ap4;
      fine5 <= fine4;
      temp5 <= temp4;
      q5    <= 32'(btpc_pkg::asr(a4, 2) * btpc_pkg::asr(a4, 2));
      ap5m  <= 32'(a4 * p5);
      p2a5  <= 32'(p2 * a4);
    end
  end
  // s6: p6 term, p3 term
  logic [31:0] fine6, temp6, b6, p3q6, p2a6;
  always_ff @(posedge clk) begin
    if (en) begin
      ap6   <= ap5;
      fine6 <= fine5;
      temp6 <= temp5;
      b6    <= 32'(btpc_pkg::asr(q5, 11) * p6) + (ap5m << 1);
      p3q6  <= 32'(p3 * btpc_pkg::asr(q5, 13));
      p2a6  <= p2a5;
    end
  end
  // s7: divisor product, b final
  logic [31:0] fine7, temp7, b7, d7;
  logic [31:0] a_c;
  assign a_c = btpc_pkg::asr(btpc_pkg::asr(p3q6, 3) + btpc_pkg::asr(p2a6, 1), 18);
  always_ff @(posedge clk) begin
    if (en) begin
      ap7   <= ap6;
      fine7 <= fine6;
      temp7 <= temp6;
      b7    <= btpc_pkg::asr(b6, 2) + (p4 << 16);
      d7    <= 32'((32'd32768 + a_c) * p1);
    end
  end
  // s8: dividend and divisor
  btpc_pkg::div_in_t di8;
  logic [31:0] den_c, pn_c;
  assign den_c = btpc_pkg::asr(d7, 15);
  assign pn_c  = 32'((32'd1048576 - {12'b0, ap7} - btpc_pkg::asr(b7, 12)) * 32'd3125);
  always_ff @(posedge clk) begin
    if (en) begin
      di8.den  <= den_c;
      di8.big  <= pn_c[31];
      di8.num  <= pn_c[31] ? pn_c : (pn_c << 1);
      di8.fine <= fine7;
      di8.temp <= temp7;
      di8.zero <= (den_c == '0);
    end
  end

  logic              dv;
  btpc_pkg::result_t dres;
  btpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v[7]),
    .din      (di8),
    .cal_c    (cal[btpc_pkg::RegPressC]),
    .out_valid(dv),
    .dout     (dres)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      temperature_centi <= dres.temp;
      fine_temperature  <= dres.fine;
      pressure_pa       <= dres.p;
      status            <= dres.status;
    end
  end

  // zero-divisor result carries zero pressure
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> pressure_pa == '0) else $error("error result nonzero");
  // stalled output holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_pa))
    else $error("output lost on stall");
  // front pipe valid bits frozen when stalled
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v)) else $error("front pipe moved during stall");
endmodule
